// ===== sv/srpc_pkg.sv =====
// Shared types and constants for the safe relative path checker.
package srpc_pkg;

    // Field widths
    localparam int unsigned CH_W    = 8;
    localparam int unsigned MAXL_W  = 12;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned PART_W  = 2;

    // Reset value of the maximum path length register
    localparam logic [MAXL_W-1:0]  MAX_LENGTH_RESET = 12'd1024;

    // Saturation limits of the running counters
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;
    localparam logic [PART_W-1:0]  PART_MAX  = 2'd3;

    // Byte codes the rules look at
    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;

    // One path request as held in the input register
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            has_char;
        logic            last;
    } t_item;

    // Verdict handed from the rule logic to the output register
    typedef struct packed {
        logic valid;
        logic safe;
    } t_result;

endpackage

// ===== sv/srpc_in_stage.sv =====
// Input register for path requests.
module srpc_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  srpc_pkg::t_item     i_item,
    input  logic                i_advance,
    output logic                o_stall,
    output logic                o_fire,
    output srpc_pkg::t_item     o_item
);

    logic            r_valid;
    logic            n_valid;
    srpc_pkg::t_item r_item;
    logic            load;

    // Held request leaves when the downstream side can take it
    assign o_fire  = r_valid && i_advance;
    assign o_stall = r_valid && !i_advance;
    assign load    = i_valid && !o_stall;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (o_fire) begin
            n_valid = 1'b0;
        end
    end

    // Control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== sv/srpc_rules.sv =====
// Running path state and the per-byte safety rules.
module srpc_rules (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_fire,
    input  srpc_pkg::t_item                       i_item,
    input  logic [srpc_pkg::MAXL_W-1:0]           i_max_length,
    output srpc_pkg::t_result                     o_result
);

    logic [srpc_pkg::COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [srpc_pkg::PART_W-1:0]  r_part_length, n_part_length;
    logic                         r_part_all_dots, n_part_all_dots;
    logic                         r_rejected, n_rejected;

    logic                         bad_char;
    logic                         is_slash;
    logic                         part_bad_now;
    logic [srpc_pkg::COUNT_W-1:0] count_a;
    logic [srpc_pkg::PART_W-1:0]  part_len_a;
    logic                         dots_a;
    logic                         rej_a;
    logic                         final_part_bad;
    logic                         len_bad;

    // Byte classification
    assign bad_char = i_item.has_char &&
                      (i_item.ch == srpc_pkg::CH_BSLASH ||
                       i_item.ch == srpc_pkg::CH_COLON  ||
                       i_item.ch == srpc_pkg::CH_NUL);
    assign is_slash = i_item.has_char && (i_item.ch == srpc_pkg::CH_SLASH);

    // Component ending here is empty, "." or ".."
    assign part_bad_now = (r_part_length == '0) ||
                          (r_part_all_dots && r_part_length != srpc_pkg::PART_MAX);

    // State after taking the byte
    always_comb begin
        part_len_a = r_part_length;
        dots_a     = r_part_all_dots;
        count_a    = r_byte_count;
        if (is_slash) begin
            part_len_a = '0;
            dots_a     = 1'b1;
        end else if (i_item.has_char) begin
            if (r_part_length != srpc_pkg::PART_MAX) begin
                part_len_a = r_part_length + 1'b1;
            end
            if (i_item.ch != srpc_pkg::CH_DOT) begin
                dots_a = 1'b0;
            end
        end
        if (i_item.has_char && r_byte_count != srpc_pkg::COUNT_MAX) begin
            count_a = r_byte_count + 1'b1;
        end
    end

    assign rej_a = r_rejected || bad_char || (is_slash && part_bad_now);

    // End-of-path checks
    assign final_part_bad = (part_len_a == '0) ||
                            (dots_a && part_len_a != srpc_pkg::PART_MAX);
    assign len_bad = (count_a == '0) ||
                     (count_a > {1'b0, i_max_length});

    assign o_result.valid = i_fire && i_item.last;
    assign o_result.safe  = !(rej_a || final_part_bad || len_bad);

    // Next state: clear after the last request of a path
    always_comb begin
        n_byte_count    = r_byte_count;
        n_part_length   = r_part_length;
        n_part_all_dots = r_part_all_dots;
        n_rejected      = r_rejected;
        if (i_fire) begin
            if (i_item.last) begin
                n_byte_count    = '0;
                n_part_length   = '0;
                n_part_all_dots = 1'b1;
                n_rejected      = 1'b0;
            end else begin
                n_byte_count    = count_a;
                n_part_length   = part_len_a;
                n_part_all_dots = dots_a;
                n_rejected      = rej_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_part_length   <= '0;
            r_part_all_dots <= 1'b1;
            r_rejected      <= 1'b0;
        end else begin
            r_byte_count    <= n_byte_count;
            r_part_length   <= n_part_length;
            r_part_all_dots <= n_part_all_dots;
            r_rejected      <= n_rejected;
        end
    end

`ifndef NO_ASSERTIONS
    // Path state is clean after a verdict
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.last |=> r_byte_count == '0 && r_part_length == '0 &&
                                  r_part_all_dots && !r_rejected)
        else $error("path state not cleared after last request");

    // A component with a non-dot byte is never empty
    a_dots_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_part_all_dots |-> r_part_length != '0)
        else $error("non-dot component with zero length");

    // No bytes seen means no component bytes and no rejection either
    a_count_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count == '0 |-> r_part_length == '0 && !r_rejected)
        else $error("component state without any byte");
`endif

endmodule

// ===== sv/srpc_out_stage.sv =====
// Output register holding one verdict until it is taken.
module srpc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srpc_pkg::t_result i_result,
    input  logic              i_out_stall,
    output logic              o_advance,
    output logic              o_valid,
    output logic              o_safe
);

    logic r_valid, n_valid;
    logic r_safe;

    // Free when empty or being taken this cycle
    assign o_advance = !r_valid || !i_out_stall;
    assign o_valid   = r_valid;
    assign o_safe    = r_safe;

    always_comb begin
        n_valid = r_valid;
        if (i_result.valid) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_safe <= i_result.safe;
        end
    end

`ifndef NO_ASSERTIONS
    // A verdict never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result.valid |-> !(r_valid && i_out_stall))
        else $error("verdict loaded while output stalled");
`endif

endmodule

// ===== sv/safe_relative_path_checker_top.sv =====
// Top level of the safe relative path checker.
//
//   channel  valid        stall        payload
//   in       i_in_valid   o_in_stall   i_ch, i_has_char, i_last
//   out      o_out_valid  i_out_stall  o_safe
//   cfg      i_cfg_we     -            i_cfg_data (max_length)
//
// One request per cycle is accepted while o_in_stall is low; the verdict for the request
// marked last passes the input register, then rule logic into the output register.
// Reset is synchronous, active low; max_length returns to 1024.
// A stall on the output backs up through the input register to o_in_stall.
module safe_relative_path_checker_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [srpc_pkg::CH_W-1:0]     i_ch,
    input  logic                          i_has_char,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_safe,
    input  logic                          i_cfg_we,
    input  logic [srpc_pkg::MAXL_W-1:0]   i_cfg_data
);

    logic [srpc_pkg::MAXL_W-1:0] r_max_length;
    srpc_pkg::t_item             in_item;
    srpc_pkg::t_item             held_item;
    srpc_pkg::t_result           result;
    logic                        fire;
    logic                        advance;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= srpc_pkg::MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_data;
        end
    end

    assign in_item.ch       = i_ch;
    assign in_item.has_char = i_has_char;
    assign in_item.last     = i_last;

    srpc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_stall   (o_in_stall),
        .o_fire    (fire),
        .o_item    (held_item)
    );

    srpc_rules u_rules (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (held_item),
        .i_max_length (r_max_length),
        .o_result     (result)
    );

    srpc_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_advance   (advance),
        .o_valid     (o_out_valid),
        .o_safe      (o_safe)
    );

endmodule

// ===== tb/sv/tb_safe_relative_path_checker_top.sv =====
// Testbench for the safe relative path checker: predicted verdicts vs. DUT output.
`timescale 1ns / 100ps

module tb_safe_relative_path_checker_top;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned PHASE_ITEMS  = 130;
    localparam int unsigned SETTLE_TICKS = 4;

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [srpc_pkg::CH_W-1:0]   i_ch       = '0;
    logic                        i_has_char = 1'b0;
    logic                        i_last     = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic                        o_safe;
    logic                        i_cfg_we   = 1'b0;
    logic [srpc_pkg::MAXL_W-1:0] i_cfg_data = '0;

    // Path requests waiting to be sent, and verdicts waiting to come back
    srpc_pkg::t_item pending_reqs[$];
    logic            safe_verdicts[$];

    // Path state as the checker should hold it
    logic [srpc_pkg::COUNT_W-1:0] seen_bytes;
    logic [srpc_pkg::PART_W-1:0]  comp_len;
    logic                         comp_dots;
    logic                         path_bad;
    logic [srpc_pkg::MAXL_W-1:0]  max_len_cfg;

    int unsigned     send_idle_pct = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     item_count = 0;
    int unsigned     err_count = 0;
    int unsigned     cycle_count = 0;
    srpc_pkg::t_item taken_req;
    srpc_pkg::t_item next_req;
    logic            want_safe;

    safe_relative_path_checker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_ch        (i_ch),
        .i_has_char  (i_has_char),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_safe      (o_safe),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Verdict prediction
    // ---------------------------------------------------------------
    task automatic clear_path_state();
        seen_bytes = '0;
        comp_len   = '0;
        comp_dots  = 1'b1;
        path_bad   = 1'b0;
    endtask

    // Component just closed is empty, "." or ".."
    function automatic logic comp_is_bad();
        return (comp_len == '0) || (comp_dots && comp_len <= 2'd2);
    endfunction

    task automatic predict_request(input srpc_pkg::t_item req);
        if (req.has_char) begin
            if (req.ch == srpc_pkg::CH_BSLASH || req.ch == srpc_pkg::CH_COLON ||
                req.ch == srpc_pkg::CH_NUL)
                path_bad = 1'b1;
            if (req.ch == srpc_pkg::CH_SLASH) begin
                if (comp_is_bad())
                    path_bad = 1'b1;
                comp_len  = '0;
                comp_dots = 1'b1;
            end else begin
                if (comp_len != srpc_pkg::PART_MAX)
                    comp_len = comp_len + 1'b1;
                if (req.ch != srpc_pkg::CH_DOT)
                    comp_dots = 1'b0;
            end
            if (seen_bytes != srpc_pkg::COUNT_MAX)
                seen_bytes = seen_bytes + 1'b1;
        end
        if (req.last) begin
            if (comp_is_bad())
                path_bad = 1'b1;
            if (seen_bytes == '0 || seen_bytes > {1'b0, max_len_cfg})
                path_bad = 1'b1;
            safe_verdicts.insert(safe_verdicts.size(), !path_bad);
            clear_path_state();
        end
    endtask

    // ---------------------------------------------------------------
    // Request driver: fed from pending_reqs
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                taken_req.ch       = i_ch;
                taken_req.has_char = i_has_char;
                taken_req.last     = i_last;
                predict_request(taken_req);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_ch       <= next_req.ch;
                    i_has_char <= next_req.has_char;
                    i_last     <= next_req.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // Verdict monitor
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (safe_verdicts.size() == 0) begin
                $error("safe: no verdict expected, actual %0b", o_safe);
                err_count++;
            end else begin
                want_safe = safe_verdicts.pop_front();
                if (o_safe !== want_safe) begin
                    $error("safe: expected %0b, actual %0b", want_safe, o_safe);
                    err_count++;
                end
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_req(input logic [srpc_pkg::CH_W-1:0] ch, input logic has_char,
                            input logic last);
        srpc_pkg::t_item req;
        req.ch       = ch;
        req.has_char = has_char;
        req.last     = last;
        pending_reqs.insert(pending_reqs.size(), req);
        item_count++;
    endtask

    // Whole path from text; end_only closes it with a byte-less request
    task automatic push_text(input string s, input bit end_only);
        int n;
        n = s.len();
        for (int i = 0; i < n; i++)
            push_req(s[i], 1'b1, !end_only && i == n - 1);
        if (end_only || n == 0)
            push_req(8'($urandom), 1'b0, 1'b1);
    endtask

    // Well-formed path of exactly len bytes: "abc/abc/..." never ending in '/'
    task automatic push_long_path(input int len);
        logic [srpc_pkg::CH_W-1:0] b;
        for (int i = 0; i < len; i++) begin
            if (i % 4 == 3 && i != len - 1)
                b = srpc_pkg::CH_SLASH;
            else
                b = 8'h61 + 8'(i % 4);
            push_req(b, 1'b1, i == len - 1);
        end
    endtask

    function automatic logic [srpc_pkg::CH_W-1:0] rand_name_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            return 8'($urandom);
        else if (r < 12)
            return srpc_pkg::CH_DOT;
        else if (r < 18)
            return 8'($urandom_range(128, 255));
        else if (r < 28)
            return 8'($urandom_range(8'h30, 8'h39));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // Random path: mostly legal components, with some bad ones mixed in
    task automatic push_rand_path();
        logic [srpc_pkg::CH_W-1:0] path_q[$];
        int unsigned               parts;
        int unsigned               k;
        int unsigned               n;
        bit                        end_only;
        end_only = ($urandom_range(3) == 0);
        if ($urandom_range(99) < 15) begin
            path_q.insert(path_q.size(), rand_name_byte());
        end else begin
            parts = $urandom_range(1, 4);
            if ($urandom_range(99) < 5)
                path_q.insert(path_q.size(), srpc_pkg::CH_SLASH);
            for (int p = 0; p < parts; p++) begin
                if (p != 0)
                    path_q.insert(path_q.size(), srpc_pkg::CH_SLASH);
                k = $urandom_range(99);
                if (k < 4) begin
                    // empty component
                end else if (k < 8) begin
                    path_q.insert(path_q.size(), srpc_pkg::CH_DOT);
                end else if (k < 12) begin
                    path_q.insert(path_q.size(), srpc_pkg::CH_DOT);
                    path_q.insert(path_q.size(), srpc_pkg::CH_DOT);
                end else if (k < 15) begin
                    repeat (3) path_q.insert(path_q.size(), srpc_pkg::CH_DOT);
                end else begin
                    repeat ($urandom_range(1, 6))
                        path_q.insert(path_q.size(), rand_name_byte());
                end
            end
            if ($urandom_range(99) < 5)
                path_q.insert(path_q.size(), srpc_pkg::CH_SLASH);
        end
        n = path_q.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 5)
                push_req(8'($urandom), 1'b0, 1'b0);
            push_req(path_q[i], 1'b1, !end_only && i == n - 1);
        end
        if (end_only || n == 0)
            push_req(8'($urandom), 1'b0, 1'b1);
    endtask

    // Poll between edges so the driver's updates of this edge are visible
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || i_in_valid || safe_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic set_max_length(input logic [srpc_pkg::MAXL_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        max_len_cfg = v;
    endtask

    task automatic push_directed();
        push_req("a", 1'b1, 1'b0);
        push_req(8'($urandom), 1'b0, 1'b0);     // empty request inside a path
        push_req("b", 1'b1, 1'b1);
        push_req(8'($urandom), 1'b0, 1'b1);     // empty path
        push_text("ab", 1'b1);
        push_text("/a", 1'b0);
        push_text("a\\b", 1'b0);
        push_text("a:b", 1'b0);
        push_req("a", 1'b1, 1'b0);
        push_req(srpc_pkg::CH_NUL, 1'b1, 1'b0);
        push_req("b", 1'b1, 1'b1);
        push_text(".", 1'b0);
        push_text("..", 1'b0);
        push_text("...", 1'b0);
        push_text("a/./b", 1'b0);
        push_text("a/../b", 1'b0);
        push_text("a//b", 1'b0);
        push_text("a/", 1'b0);
        push_text(".a/b./...", 1'b1);
        push_req(8'hFF, 1'b1, 1'b1);
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        logic [srpc_pkg::MAXL_W-1:0] phase_max [8];
        int unsigned                 mode;
        int unsigned                 phase_start;
        phase_max = '{12'd1024, 12'd8, 12'd1, 12'd0, 12'd4095, 12'd12, 12'd5,
                      12'($urandom_range(2, 20))};
        max_len_cfg = srpc_pkg::MAX_LENGTH_RESET;
        clear_path_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 8; p++) begin
            mode = p % 4;
            // first phase runs on the reset value of max_length
            if (p != 0)
                set_max_length(phase_max[p]);
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            phase_start = item_count;
            if (p == 0)
                push_directed();
            if (p == 1) begin
                // right at and just over the length limit
                push_long_path(8);
                push_long_path(9);
            end
            while (item_count - phase_start < PHASE_ITEMS)
                push_rand_path();
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (err_count == 0 && safe_verdicts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
